>>> hdl/best_fit_range_allocator_core_defines.svh
// Assertion macros used by the allocator port checker.
`ifndef BEST_FIT_RANGE_ALLOCATOR_CORE_DEFINES_SVH
`define BEST_FIT_RANGE_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication.
`define BFRA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bfra: check failed");

// Next-cycle implication.
`define BFRA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bfra: check failed");

`endif

>>> hdl/bfra_pkg.sv
// Types and constants of the best-fit range allocator.
`timescale 1ns / 1ps

package bfra_pkg;

   localparam int COUNT_W    = 11;
   localparam int OFF_OUT_W  = 10;
   localparam int ADDR_W     = 48;
   localparam int STRIDE_W   = 9;
   localparam int PAGE_W     = 11;
   localparam int AGE_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;

   localparam logic [AGE_W-1:0] AGE_LAST = '1;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_SIZE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_STRIDE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CPU_BASE       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GPU_BASE       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SHADER_VISIBLE = 3'd4;

   typedef struct packed {
      logic                req_type;
      logic [COUNT_W-1:0]  slot_count;
      logic [ADDR_W-1:0]   free_address;
   } bfra_req_type;

   typedef struct packed {
      logic                 status;
      logic [OFF_OUT_W-1:0] slot_offset;
      logic [ADDR_W-1:0]    cpu_address;
      logic [ADDR_W-1:0]    gpu_address;
      logic [COUNT_W-1:0]   free_total;
   } bfra_rsp_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DIV,
      S_SCAN,
      S_DECIDE,
      S_KILL,
      S_PUT,
      S_RN_READ,
      S_RN_LATCH,
      S_RN_COUNT,
      S_RN_STORE,
      S_RN_COPY,
      S_MUL,
      S_RESP
   } bfra_state_type;

endpackage

>>> hdl/bfra_div.sv
// Restoring divider: address difference over slot stride, one bit per cycle.
`timescale 1ns / 1ps

module bfra_div import bfra_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [ADDR_W-1:0]   dividend,
   input  logic [STRIDE_W-1:0] divisor,
   output logic                done,
   output logic [ADDR_W-1:0]   quotient
);

   localparam int SW = $clog2(ADDR_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [SW-1:0]       step_ff, step_in;
   logic [ADDR_W-1:0]   quo_ff, quo_in;
   logic [STRIDE_W-1:0] rem_ff, rem_in;
   logic [STRIDE_W-1:0] div_ff, div_in;
   logic [STRIDE_W:0]   rem_sh;
   logic                ge;

   assign rem_sh = {rem_ff, quo_ff[ADDR_W-1]};
   assign ge     = rem_sh >= {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[ADDR_W-2:0], ge};
         rem_in  = ge ? STRIDE_W'(rem_sh - {1'b0, div_ff}) : rem_sh[STRIDE_W-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == SW'(ADDR_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   // a zero stride maps every address to slot zero
   assign done     = done_ff;
   assign quotient = (div_ff == '0) ? '0 : quo_ff;

endmodule

>>> hdl/best_fit_range_allocator_core.sv
// Best-fit range allocator: free-range table in one memory, scanned per item.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------
//  req     | in  | req_valid/req_ready  | req_data  (bfra_req_type)
//  rsp     | out | rsp_valid/rsp_ready  | rsp_data  (bfra_rsp_type)
//  csr     | in  | csr_valid/csr_ready  | csr_index, csr_data
//
// One item at a time. Each item scans the whole range table through the one
// memory read port. A free first runs the divider; every item ends with a
// decision, a write-back when accepted, and the response. When the age
// counter reaches its last value on an insertion, the ages are renumbered
// before that item's response. After reset and after every page_size write
// a clearing pass rebuilds the table; req_ready stays low meanwhile, csr is
// always ready. The response sits in an output register, so the next item
// is taken while a finished one waits on rsp_ready.
`timescale 1ns / 1ps

module best_fit_range_allocator_core import bfra_pkg::*; #(
   parameter int PAGE_CAPACITY = 1024,
   parameter int MAX_RANGES    = 512
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  bfra_req_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output bfra_rsp_type          rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int OW = $clog2(PAGE_CAPACITY);          // slot offset
   localparam int LW = $clog2(PAGE_CAPACITY + 1);      // range length
   localparam int CW = (LW > COUNT_W) ? LW : COUNT_W;
   localparam int EW = CW + 1;                          // sums of offsets
   localparam int IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam int NW = $clog2(MAX_RANGES + 1);
   localparam int MW = OW + STRIDE_W;

   typedef struct packed {
      logic             valid;
      logic [OW-1:0]    start;
      logic [LW-1:0]    length;
      logic [AGE_W-1:0] age;
      logic [AGE_W-1:0] rank;    // scratch for age renumbering
   } entry_type;

   // state machine
   bfra_state_type state_ff, state_in, post_state;

   // configuration
   logic [PAGE_W-1:0]   page_size_ff;
   logic [STRIDE_W-1:0] stride_ff;
   logic [ADDR_W-1:0]   cpu_base_ff, gpu_base_ff;
   logic                shader_vis_ff;
   logic                csr_wr, page_wr;

   // allocator state
   logic [LW-1:0]    free_slots_ff;
   logic [AGE_W-1:0] counter_ff;
   logic [LW-1:0]    page_eff;

   // item
   logic              is_free_ff;
   logic [COUNT_W-1:0] cnt_ff;
   logic [OW-1:0]     off_ff;
   logic              range_ok_ff;
   logic              ok_ff;

   // table memory
   entry_type        mem [MAX_RANGES];
   entry_type        rd_data_ff;
   logic             rd_en, wr_en;
   logic [IW-1:0]    rd_addr, wr_addr;
   entry_type        wr_data;

   // scan sequencing
   logic [NW-1:0] clr_ff, issue_ff;
   logic          pend_ff;
   logic [IW-1:0] pend_idx_ff;
   logic          scanning, scan_rd, scan_done, clr_last;

   // best fit
   logic          found_ff;
   logic [IW-1:0] best_idx_ff;
   logic [OW-1:0] best_start_ff;
   logic [LW-1:0] best_len_ff;
   logic [AGE_W-1:0] best_age_ff;

   // neighbors of a freed range
   logic          overlap_ff, have_prev_ff, have_next_ff, have_slot_ff;
   logic [IW-1:0] prev_idx_ff, next_idx_ff, slot_idx_ff;
   logic [OW-1:0] prev_start_ff;
   logic [LW-1:0] prev_len_ff, next_len_ff;

   // write-back plan
   logic          put_live_ff;
   logic [IW-1:0] put_idx_ff;
   entry_type     put_entry_ff;

   // renumbering
   logic [NW-1:0] rn_idx_ff, rank_ff, nvalid_ff;
   entry_type     rn_entry_ff;
   logic          rn_last;

   // address step and output register
   logic [MW-1:0]  step_ff;
   logic           rsp_valid_ff;
   bfra_rsp_type   rsp_data_ff, rsp_next;
   logic           rsp_load;

   // divider
   logic              div_start, div_done;
   logic [ADDR_W-1:0] div_q;

   // scan compares, widened so sums never wrap
   logic [EW-1:0] e_start, e_len, e_end, off_e, cnt_e, off_end, free_e;
   logic          alloc_ok, free_ok, ok_now, kill_now;
   logic [EW-1:0] merged_len;
   entry_type     init_entry, alloc_put, free_put, copy_entry, rank_entry;

   assign page_eff = (EW'(page_size_ff) > EW'(PAGE_CAPACITY)) ?
                     LW'(PAGE_CAPACITY) : LW'(page_size_ff);

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;
   assign page_wr   = csr_wr && (csr_index == CSR_PAGE_SIZE);

   assign req_ready = (state_ff == S_IDLE);

   assign scanning  = (state_ff == S_SCAN) || (state_ff == S_RN_COUNT) ||
                      (state_ff == S_RN_COPY);
   assign scan_rd   = scanning && (issue_ff != NW'(MAX_RANGES));
   assign scan_done = scanning && (issue_ff == NW'(MAX_RANGES)) && !pend_ff;
   assign clr_last  = (clr_ff == NW'(MAX_RANGES - 1));
   assign rn_last   = (rn_idx_ff == NW'(MAX_RANGES - 1));

   assign div_start = req_valid && req_ready && (req_data.req_type == REQ_FREE);

   bfra_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_data.free_address - cpu_base_ff),
      .divisor  (stride_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign e_start = EW'(rd_data_ff.start);
   assign e_len   = EW'(rd_data_ff.length);
   assign e_end   = e_start + e_len;
   assign off_e   = EW'(off_ff);
   assign cnt_e   = EW'(cnt_ff);
   assign off_end = off_e + cnt_e;
   assign free_e  = EW'(free_slots_ff);

   // decision after the scan
   assign alloc_ok = (cnt_ff != '0) && (cnt_e <= free_e) && found_ff;
   assign free_ok  = (cnt_ff != '0) && range_ok_ff && !overlap_ff &&
                     (have_prev_ff || have_next_ff || have_slot_ff);
   assign ok_now   = is_free_ff ? free_ok : alloc_ok;
   assign kill_now = is_free_ff && have_prev_ff && have_next_ff;

   assign merged_len = cnt_e + (have_prev_ff ? EW'(prev_len_ff) : '0) +
                       (have_next_ff ? EW'(next_len_ff) : '0);

   always_comb begin
      init_entry        = '0;
      init_entry.valid  = (page_eff != '0);
      init_entry.length = page_eff;

      alloc_put        = '0;
      alloc_put.valid  = 1'b1;
      alloc_put.start  = OW'(EW'(best_start_ff) + cnt_e);
      alloc_put.length = LW'(EW'(best_len_ff) - cnt_e);
      alloc_put.age    = counter_ff;

      free_put        = '0;
      free_put.valid  = 1'b1;
      free_put.start  = have_prev_ff ? prev_start_ff : off_ff;
      free_put.length = LW'(merged_len);
      free_put.age    = counter_ff;

      copy_entry     = rd_data_ff;
      copy_entry.age = rd_data_ff.rank;

      rank_entry      = rn_entry_ff;
      rank_entry.rank = AGE_W'(rank_ff);
   end

   assign post_state = is_free_ff ? S_RESP : S_MUL;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR:    if (clr_last) state_in = S_IDLE;
         S_IDLE: begin
            if (req_valid) begin
               state_in = (req_data.req_type == REQ_FREE) ? S_DIV : S_SCAN;
            end
         end
         S_DIV:      if (div_done) state_in = S_SCAN;
         S_SCAN:     if (scan_done) state_in = S_DECIDE;
         S_DECIDE: begin
            if (!ok_now)       state_in = S_RESP;
            else if (kill_now) state_in = S_KILL;
            else               state_in = S_PUT;
         end
         S_KILL:     state_in = S_PUT;
         S_PUT: begin
            if (put_live_ff && (counter_ff == AGE_LAST)) state_in = S_RN_READ;
            else                                          state_in = post_state;
         end
         S_RN_READ:  state_in = S_RN_LATCH;
         S_RN_LATCH: begin
            if (rd_data_ff.valid) state_in = S_RN_COUNT;
            else if (rn_last)     state_in = S_RN_COPY;
            else                  state_in = S_RN_READ;
         end
         S_RN_COUNT: if (scan_done) state_in = S_RN_STORE;
         S_RN_STORE: state_in = rn_last ? S_RN_COPY : S_RN_READ;
         S_RN_COPY:  if (scan_done) state_in = post_state;
         S_MUL:      state_in = S_RESP;
         S_RESP:     if (!rsp_valid_ff || rsp_ready) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
      // a new page size rebuilds the table
      if (page_wr) state_in = S_CLEAR;
   end

   // memory port control
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = issue_ff[IW-1:0];
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff[IW-1:0];
            wr_data = (clr_ff == '0) ? init_entry : '0;
         end
         S_SCAN, S_RN_COUNT: rd_en = scan_rd;
         S_RN_COPY: begin
            rd_en   = scan_rd;
            wr_en   = pend_ff;
            wr_addr = pend_idx_ff;
            wr_data = copy_entry;
         end
         S_KILL: begin
            wr_en   = 1'b1;
            wr_addr = next_idx_ff;
         end
         S_PUT: begin
            wr_en   = 1'b1;
            wr_addr = put_idx_ff;
            wr_data = put_live_ff ? put_entry_ff : '0;
         end
         S_RN_READ: begin
            rd_en   = 1'b1;
            rd_addr = rn_idx_ff[IW-1:0];
         end
         S_RN_STORE: begin
            wr_en   = 1'b1;
            wr_addr = rn_idx_ff[IW-1:0];
            wr_data = rank_entry;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   // response word
   always_comb begin
      logic [ADDR_W-1:0] step_w;
      step_w   = ADDR_W'(step_ff);
      rsp_next = '0;
      rsp_next.status     = ok_ff ? STATUS_OK : STATUS_REJECT;
      rsp_next.free_total = COUNT_W'(free_slots_ff);
      if (ok_ff) begin
         rsp_next.slot_offset = OFF_OUT_W'(off_ff);
         if (!is_free_ff) begin
            rsp_next.cpu_address = cpu_base_ff + step_w;
            rsp_next.gpu_address = shader_vis_ff ? (gpu_base_ff + step_w) : gpu_base_ff;
         end
      end
   end

   assign rsp_load  = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         issue_ff      <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         page_size_ff  <= PAGE_W'(1024);
         stride_ff     <= STRIDE_W'(32);
         cpu_base_ff   <= '0;
         gpu_base_ff   <= '0;
         shader_vis_ff <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (page_wr)                  clr_ff <= '0;
         else if (state_ff == S_CLEAR) clr_ff <= clr_ff + 1'b1;

         if (scan_rd)        issue_ff <= issue_ff + 1'b1;
         else if (!scanning) issue_ff <= '0;
         pend_ff <= scan_rd;

         if (rsp_load)       rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;

         if (csr_wr) begin
            unique case (csr_index)
               CSR_PAGE_SIZE:      page_size_ff  <= csr_data[PAGE_W-1:0];
               CSR_SLOT_STRIDE:    stride_ff     <= csr_data[STRIDE_W-1:0];
               CSR_CPU_BASE:       cpu_base_ff   <= csr_data[ADDR_W-1:0];
               CSR_GPU_BASE:       gpu_base_ff   <= csr_data[ADDR_W-1:0];
               CSR_SHADER_VISIBLE: shader_vis_ff <= csr_data[0];
               default: ;
            endcase
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      pend_idx_ff <= issue_ff[IW-1:0];
      if (rsp_load) rsp_data_ff <= rsp_next;

      case (state_ff)
         S_CLEAR: begin
            free_slots_ff <= page_eff;
            counter_ff    <= AGE_W'(1);
         end
         S_IDLE: begin
            is_free_ff   <= (req_data.req_type == REQ_FREE);
            cnt_ff       <= req_data.slot_count;
            found_ff     <= 1'b0;
            overlap_ff   <= 1'b0;
            have_prev_ff <= 1'b0;
            have_next_ff <= 1'b0;
            have_slot_ff <= 1'b0;
         end
         S_DIV: begin
            if (div_done) begin
               off_ff      <= OW'(div_q);
               range_ok_ff <= (div_q < ADDR_W'(page_eff)) &&
                              (cnt_e <= EW'(page_eff) - EW'(div_q));
            end
         end
         S_SCAN: begin
            if (pend_ff) begin
               if (rd_data_ff.valid) begin
                  if ((e_len >= cnt_e) &&
                      (!found_ff || (rd_data_ff.length < best_len_ff) ||
                       ((rd_data_ff.length == best_len_ff) &&
                        (rd_data_ff.age < best_age_ff)))) begin
                     found_ff      <= 1'b1;
                     best_idx_ff   <= pend_idx_ff;
                     best_start_ff <= rd_data_ff.start;
                     best_len_ff   <= rd_data_ff.length;
                     best_age_ff   <= rd_data_ff.age;
                  end
                  if ((e_start < off_end) && (off_e < e_end)) overlap_ff <= 1'b1;
                  if (e_end == off_e) begin
                     have_prev_ff  <= 1'b1;
                     prev_idx_ff   <= pend_idx_ff;
                     prev_start_ff <= rd_data_ff.start;
                     prev_len_ff   <= rd_data_ff.length;
                  end
                  if (e_start == off_end) begin
                     have_next_ff <= 1'b1;
                     next_idx_ff  <= pend_idx_ff;
                     next_len_ff  <= rd_data_ff.length;
                  end
               end else if (!have_slot_ff) begin
                  have_slot_ff <= 1'b1;
                  slot_idx_ff  <= pend_idx_ff;
               end
            end
         end
         S_DECIDE: begin
            ok_ff <= ok_now;
            if (is_free_ff) begin
               put_live_ff  <= 1'b1;
               put_entry_ff <= free_put;
               if (have_prev_ff)      put_idx_ff <= prev_idx_ff;
               else if (have_next_ff) put_idx_ff <= next_idx_ff;
               else                   put_idx_ff <= slot_idx_ff;
               if (free_ok) free_slots_ff <= LW'(free_e + cnt_e);
            end else begin
               // an exact fit just retires the entry
               put_live_ff  <= (EW'(best_len_ff) > cnt_e);
               put_entry_ff <= alloc_put;
               put_idx_ff   <= best_idx_ff;
               off_ff       <= best_start_ff;
               if (alloc_ok) free_slots_ff <= LW'(free_e - cnt_e);
            end
         end
         S_PUT: begin
            rn_idx_ff <= '0;
            nvalid_ff <= '0;
            if (put_live_ff) counter_ff <= counter_ff + 1'b1;
         end
         S_RN_LATCH: begin
            rn_entry_ff <= rd_data_ff;
            rank_ff     <= '0;
            if (!rd_data_ff.valid) rn_idx_ff <= rn_idx_ff + 1'b1;
         end
         S_RN_COUNT: begin
            if (pend_ff && rd_data_ff.valid && (rd_data_ff.age < rn_entry_ff.age)) begin
               rank_ff <= rank_ff + 1'b1;
            end
         end
         S_RN_STORE: begin
            nvalid_ff <= nvalid_ff + 1'b1;
            rn_idx_ff <= rn_idx_ff + 1'b1;
         end
         S_RN_COPY: begin
            if (scan_done) counter_ff <= AGE_W'(nvalid_ff);
         end
         S_MUL: step_ff <= MW'(off_ff * stride_ff);
         default: ;
      endcase
   end

endmodule

>>> hdl/bfra_checker.sv
// Port-level checks of the best-fit range allocator and their binding.
`timescale 1ns / 1ps
`include "best_fit_range_allocator_core_defines.svh"

module bfra_checker import bfra_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input bfra_rsp_type         rsp_data,
   input logic                 csr_valid,
   input logic                 csr_ready,
   input logic [CSR_IDX_W-1:0] csr_index
);

   // a stalled result holds
   `BFRA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // a rejected item reports no slot and no address
   `BFRA_ASSERT_NOW(a_reject_zero, clock, reset, rsp_valid && (rsp_data.status == STATUS_REJECT), (rsp_data.slot_offset == '0) && (rsp_data.cpu_address == '0) && (rsp_data.gpu_address == '0))

   // one item at a time: busy right after an accept
   `BFRA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   // the table rebuild blocks new items after reset and page resize
   `BFRA_ASSERT_NOW(a_clear_after_reset, clock, reset, $fell(reset), !req_ready)
   `BFRA_ASSERT_NEXT(a_clear_after_resize, clock, reset, csr_valid && csr_ready && (csr_index == CSR_PAGE_SIZE), !req_ready)

endmodule

bind best_fit_range_allocator_core bfra_checker u_bfra_checker (.*);

>>> test/bfra_grant_checker.sv
// Checker for the best-fit range allocator: predicts each result and compares.
`timescale 1ns / 1ps

module bfra_grant_checker import bfra_pkg::*; #(
   parameter int PAGE_CAPACITY = 1024,
   parameter int MAX_RANGES    = 512
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  bfra_req_type          req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  bfra_rsp_type          rsp_data,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    fail_count,
   output int                    grants_due,
   output int                    grants_seen
);

   localparam int AGE_SPAN = 65536;

   // shadow registers
   logic [PAGE_W-1:0]   page_reg;
   logic [STRIDE_W-1:0] stride_reg;
   logic [ADDR_W-1:0]   cpu_reg;
   logic [ADDR_W-1:0]   gpu_reg;
   logic                visible_reg;

   // shadow free-range table
   int unsigned span_start [MAX_RANGES];
   int unsigned span_len   [MAX_RANGES];
   int unsigned span_age   [MAX_RANGES];
   bit          span_live  [MAX_RANGES];
   int unsigned slots_free;
   int unsigned next_age;

   bfra_rsp_type expected_grants[$];

   function automatic int unsigned usable_slots();
      return (32'(page_reg) > PAGE_CAPACITY) ? PAGE_CAPACITY : 32'(page_reg);
   endfunction

   function automatic void clear_table();
      int unsigned n;
      n = usable_slots();
      for (int i = 0; i < MAX_RANGES; i++) begin
         span_start[i] = 0;
         span_len[i]   = 0;
         span_age[i]   = 0;
         span_live[i]  = 0;
      end
      if (n > 0) begin
         span_len[0]  = n;
         span_live[0] = 1;
      end
      slots_free = n;
      next_age   = 1;
   endfunction

   // ages restart at 0..n-1 in their old order once the counter runs out
   function automatic void compact_ages();
      int unsigned rank [MAX_RANGES];
      int unsigned n;
      n = 0;
      for (int i = 0; i < MAX_RANGES; i++) begin
         rank[i] = 0;
         if (span_live[i]) begin
            for (int j = 0; j < MAX_RANGES; j++)
               if (span_live[j] && span_age[j] < span_age[i]) rank[i]++;
            n++;
         end
      end
      for (int i = 0; i < MAX_RANGES; i++)
         if (span_live[i]) span_age[i] = rank[i];
      next_age = n;
   endfunction

   function automatic void place_span(int idx, int unsigned s, int unsigned l);
      span_start[idx] = s;
      span_len[idx]   = l;
      span_live[idx]  = 1;
      span_age[idx]   = next_age;
      next_age++;
      if (next_age >= AGE_SPAN) compact_ages();
   endfunction

   function automatic bfra_rsp_type predict_grant(bfra_req_type r);
      bfra_rsp_type g;
      int unsigned cnt, off, page, s, l;
      int best, prv, nxt, hole;
      logic [ADDR_W-1:0] diff, q, step;
      bit ok;
      cnt  = 32'(r.slot_count);
      off  = 0;
      ok   = 0;
      g    = '0;
      best = -1;
      if (r.req_type == REQ_ALLOC) begin
         if (cnt != 0 && cnt <= slots_free) begin
            for (int i = 0; i < MAX_RANGES; i++) begin
               if (!span_live[i] || span_len[i] < cnt) continue;
               if (best < 0 || span_len[i] < span_len[best] ||
                   (span_len[i] == span_len[best] && span_age[i] < span_age[best]))
                  best = i;
            end
         end
         if (best >= 0) begin
            ok  = 1;
            off = span_start[best];
            span_live[best] = 0;
            if (span_len[best] > cnt)
               place_span(best, span_start[best] + cnt, span_len[best] - cnt);
            slots_free -= cnt;
            step = ADDR_W'(off) * ADDR_W'(stride_reg);
            g.cpu_address = cpu_reg + step;
            g.gpu_address = visible_reg ? gpu_reg + step : gpu_reg;
         end
      end else begin
         page = usable_slots();
         diff = r.free_address - cpu_reg;
         q    = (stride_reg != 0) ? diff / ADDR_W'(stride_reg) : '0;
         ok   = (cnt != 0 && q < ADDR_W'(page) && cnt <= page - 32'(q));
         if (ok) begin
            off  = 32'(q);
            prv  = -1;
            nxt  = -1;
            hole = -1;
            for (int i = 0; i < MAX_RANGES; i++) begin
               if (!span_live[i]) begin
                  if (hole < 0) hole = i;
                  continue;
               end
               // any overlap with a free range is a double free
               if (span_start[i] < off + cnt && off < span_start[i] + span_len[i])
                  ok = 0;
               if (span_start[i] + span_len[i] == off) prv = i;
               if (span_start[i] == off + cnt) nxt = i;
            end
            if (ok && prv < 0 && nxt < 0 && hole < 0) ok = 0;
            if (ok) begin
               s = off;
               l = cnt;
               if (prv >= 0) begin
                  s = span_start[prv];
                  l += span_len[prv];
                  span_live[prv] = 0;
                  hole = prv;
               end
               if (nxt >= 0) begin
                  l += span_len[nxt];
                  span_live[nxt] = 0;
                  if (prv < 0) hole = nxt;
               end
               place_span(hole, s, l);
               slots_free += cnt;
            end
         end
      end
      g.status      = ok ? STATUS_OK : STATUS_REJECT;
      g.slot_offset = ok ? OFF_OUT_W'(off) : '0;
      g.free_total  = COUNT_W'(slots_free);
      return g;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, field, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      bfra_rsp_type want;
      if (reset) begin
         page_reg    = 11'd1024;
         stride_reg  = 9'd32;
         cpu_reg     = '0;
         gpu_reg     = '0;
         visible_reg = 1'b0;
         clear_table();
         expected_grants.delete();
         fail_count  = 0;
         grants_due  = 0;
         grants_seen <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            grants_seen <= grants_seen + 1;
            if (expected_grants.size() == 0) begin
               report_mismatch("result count", 1, 0);
            end else begin
               want = expected_grants.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch("status", rsp_data.status, want.status);
               if (rsp_data.slot_offset !== want.slot_offset)
                  report_mismatch("slot_offset", rsp_data.slot_offset, want.slot_offset);
               if (rsp_data.cpu_address !== want.cpu_address)
                  report_mismatch("cpu_address", rsp_data.cpu_address, want.cpu_address);
               if (rsp_data.gpu_address !== want.gpu_address)
                  report_mismatch("gpu_address", rsp_data.gpu_address, want.gpu_address);
               if (rsp_data.free_total !== want.free_total)
                  report_mismatch("free_total", rsp_data.free_total, want.free_total);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PAGE_SIZE: begin
                  page_reg = csr_data[PAGE_W-1:0];
                  clear_table();
               end
               CSR_SLOT_STRIDE:    stride_reg  = csr_data[STRIDE_W-1:0];
               CSR_CPU_BASE:       cpu_reg     = csr_data[ADDR_W-1:0];
               CSR_GPU_BASE:       gpu_reg     = csr_data[ADDR_W-1:0];
               CSR_SHADER_VISIBLE: visible_reg = csr_data[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            expected_grants.insert(expected_grants.size(), predict_grant(req_data));
         grants_due = expected_grants.size();
      end
   end

endmodule

>>> test/best_fit_range_allocator_core_tb.sv
// Testbench top: stimulus, idling and verdict for the best-fit range allocator.
`timescale 1ns / 1ps

module best_fit_range_allocator_core_tb;
   import bfra_pkg::*;

   localparam int STALL_LIMIT = 20000;

   // register indexes past the end of the list
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LOW = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_TOP = 3'd7;

   typedef struct {
      int unsigned off;
      int unsigned cnt;
   } slot_run_type;

   typedef struct {
      logic        kind;
      int unsigned cnt;
   } sent_item_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   bfra_req_type          req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   bfra_rsp_type          rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   int fail_count;
   int grants_due;
   int grants_seen;

   // what the stimulus knows of the current setting
   int unsigned         cur_page;
   logic [STRIDE_W-1:0] cur_stride;
   logic [ADDR_W-1:0]   cur_cpu;

   slot_run_type  held_runs[$];   // granted ranges not yet released
   sent_item_type sent_items[$];
   slot_run_type  last_freed;
   bit            no_gaps;
   int            idle_cycles;
   int            items_sent;
   int            phases_run;

   best_fit_range_allocator_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   bfra_grant_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .grants_due  (grants_due),
      .grants_seen (grants_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Track granted ranges so frees can hit live allocations; watchdog on handshakes.
   always @(posedge clock) begin
      sent_item_type s;
      slot_run_type  r;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
            $display("FAIL best_fit_range_allocator_core");
            $finish;
         end
         if (rsp_valid && rsp_ready && sent_items.size() > 0) begin
            s = sent_items.pop_front();
            if (s.kind == REQ_ALLOC && rsp_data.status == STATUS_OK) begin
               r.off = 32'(rsp_data.slot_offset);
               r.cnt = s.cnt;
               held_runs.insert(held_runs.size(), r);
            end
         end
      end
   end

   // Result side: random stall per item, none while no_gaps is set.
   initial begin
      int n;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         n = no_gaps ? 0 : $urandom_range(0, 7);
         if (n > 0) begin
            rsp_ready = 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!(rsp_valid === 1'b1));
         @(negedge clock);
      end
   end

   // Valid is left high between items when no gap is drawn.
   task automatic send_item(input logic kind, input int unsigned cnt,
                            input logic [ADDR_W-1:0] addr);
      int gap;
      sent_item_type s;
      gap = no_gaps ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid             = 1'b1;
      req_data.req_type     = kind;
      req_data.slot_count   = COUNT_W'(cnt);
      req_data.free_address = addr;
      do @(posedge clock); while (!req_ready);
      s.kind = kind;
      s.cnt  = cnt;
      sent_items.insert(sent_items.size(), s);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid = 1'b0;
      wait (grants_due == 0 && sent_items.size() == 0);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
      case (idx)
         CSR_PAGE_SIZE: begin
            cur_page = (val[PAGE_W-1:0] > PAGE_W'(1024)) ? 1024 : 32'(val[PAGE_W-1:0]);
            held_runs.delete();
         end
         CSR_SLOT_STRIDE: cur_stride = val[STRIDE_W-1:0];
         CSR_CPU_BASE:    cur_cpu    = val[ADDR_W-1:0];
         default: ;
      endcase
   endtask

   function automatic logic [ADDR_W-1:0] slot_addr(int unsigned off);
      logic [ADDR_W-1:0] a;
      a = cur_cpu + ADDR_W'(off) * ADDR_W'(cur_stride);
      if (cur_stride > 1) a += ADDR_W'($urandom_range(0, 32'(cur_stride) - 1));
      return a;
   endfunction

   // Mostly well-formed: allocations and releases of live ranges, some noise.
   task automatic random_item();
      int unsigned pick, k, cnt;
      int idx;
      slot_run_type r, rest;
      pick = $urandom_range(0, 99);
      if (pick < 50 || (pick < 88 && held_runs.size() == 0)) begin
         if ($urandom_range(0, 9) < 8) cnt = $urandom_range(1, 12);
         else cnt = $urandom_range(1, cur_page + 2);
         send_item(REQ_ALLOC, cnt, ADDR_W'({$urandom, $urandom}));
      end else if (pick < 88) begin
         idx = $urandom_range(0, held_runs.size() - 1);
         r = held_runs[idx];
         held_runs.delete(idx);
         k = $urandom_range(1, r.cnt);
         case ($urandom_range(0, 2))
            0: k = r.cnt;
            1: begin
               rest.off = r.off + k;
               rest.cnt = r.cnt - k;
               if (rest.cnt > 0) held_runs.insert(held_runs.size(), rest);
               r.cnt = k;
            end
            default: begin
               rest.off = r.off;
               rest.cnt = r.cnt - k;
               if (rest.cnt > 0) held_runs.insert(held_runs.size(), rest);
               r.off = r.off + r.cnt - k;
               r.cnt = k;
            end
         endcase
         last_freed = r;
         send_item(REQ_FREE, r.cnt, slot_addr(r.off));
      end else if (pick < 94) begin
         // release the same range twice
         send_item(REQ_FREE, last_freed.cnt, slot_addr(last_freed.off));
      end else begin
         send_item(1'($urandom_range(0, 1)), $urandom_range(0, 2047),
                   ADDR_W'({$urandom, $urandom}));
      end
   endtask

   task automatic run_phase(input logic [PAGE_W-1:0] page, input logic [STRIDE_W-1:0] stride,
                            input logic [ADDR_W-1:0] cpu, input logic [ADDR_W-1:0] gpu,
                            input logic visible, input int items, input bit quiet);
      drain();
      write_csr(CSR_SLOT_STRIDE, CSR_DATA_W'(stride));
      write_csr(CSR_CPU_BASE, CSR_DATA_W'(cpu));
      write_csr(CSR_GPU_BASE, CSR_DATA_W'(gpu));
      write_csr(CSR_SHADER_VISIBLE, CSR_DATA_W'(visible));
      write_csr(CSR_PAGE_SIZE, CSR_DATA_W'(page));
      no_gaps = quiet;
      for (int i = 0; i < items; i++) begin
         random_item();
         // let the block run dry once mid-phase
         if (i == items / 2 && phases_run == 1) drain();
      end
      phases_run++;
   endtask

   initial begin
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      no_gaps    = 1'b0;
      cur_page   = 1024;
      cur_stride = 9'd32;
      cur_cpu    = '0;
      items_sent = 0;
      phases_run = 0;
      last_freed.off = 0;
      last_freed.cnt = 1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part at reset settings: page 1024, stride 32, bases zero.
      send_item(REQ_ALLOC, 0, '0);              // zero count
      send_item(REQ_ALLOC, 2047, '0);           // wider than the page
      send_item(REQ_ALLOC, 1025, '0);           // more than free
      send_item(REQ_ALLOC, 1024, '0);           // whole page
      send_item(REQ_ALLOC, 1, '0);              // nothing left
      send_item(REQ_FREE, 0, '0);               // zero count free
      send_item(REQ_FREE, 1024, '0);            // whole page back
      send_item(REQ_ALLOC, 100, '0);
      send_item(REQ_ALLOC, 100, '0);
      send_item(REQ_ALLOC, 100, '0);
      send_item(REQ_FREE, 100, 48'd3200 + 48'd17); // hole in the middle, unaligned address
      send_item(REQ_ALLOC, 50, '0);             // best fit picks the hole
      send_item(REQ_FREE, 100, 48'd3200 + 48'd1600); // overlaps free space: double free
      send_item(REQ_FREE, 10, 48'd32 * 48'd1020);    // runs past the page end
      send_item(REQ_FREE, 1, '1);               // address far outside
      send_item(REQ_FREE, 50, '0);              // frees slots 0..49
      send_item(REQ_ALLOC, 20, '0);
      send_item(REQ_ALLOC, 20, '0);             // the one above breaks an equal-size tie: the older range goes first
      send_item(REQ_FREE, 50, 48'd32 * 48'd250);
      send_item(REQ_FREE, 100, 48'd32 * 48'd200);  // partly free already
      send_item(REQ_ALLOC, 724, '0);
      drain();
      write_csr(CSR_UNUSED_LOW, '1);            // indexes past the list are ignored
      write_csr(CSR_UNUSED_TOP, '0);

      run_phase(11'd7, 9'd1, '1, 48'hFFFF_FFFF_FFF0, 1'b1, 40, 1'b0);
      run_phase(11'd1024, 9'd256, {$urandom, $urandom}, {$urandom, $urandom}, 1'b1, 110, 1'b0);
      run_phase(11'd0, 9'd32, '0, 48'h1234, 1'b1, 12, 1'b0);
      run_phase(11'd2047, 9'd0, 48'h8000_0000_0000, '1, 1'b0, 40, 1'b1);
      run_phase(11'd64, 9'd17, {$urandom, $urandom}, {$urandom, $urandom}, 1'b0, 120, 1'b0);
      run_phase(11'd1, 9'd3, '0, '0, 1'b1, 30, 1'b1);
      run_phase(11'd300, 9'd8, {$urandom, $urandom}, {$urandom, $urandom}, 1'b1, 100, 1'b0);

      drain();
      repeat (20) @(posedge clock);
      $display("covered %0d requests, %0d results over %0d register settings",
               items_sent, grants_seen, phases_run + 1);
      $display("settings spanned page sizes 0 to 2047, strides 0 to 256, wrapped bases");
      if (fail_count == 0) begin
         $display("PASS best_fit_range_allocator_core");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("FAIL best_fit_range_allocator_core");
      end
      $finish;
   end

endmodule
